>>> rtl/sjf_pkg.sv
package sjf_pkg;

    localparam int IN_BURST_W = 16;
    localparam int PROC_W     = 5;
    localparam int TIME_W     = 20;
    localparam int AVG_W      = 28;
    localparam int FRAC_BITS  = 8;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

>>> rtl/sjf_cell.sv
module sjf_cell import sjf_pkg::*; #(
    parameter int BW  = 16,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [CW-1:0] i_count,
    input  logic [BW-1:0] i_new_burst,
    input  logic [CW-1:0] i_new_id,
    input  logic          i_left_gt,
    input  logic [BW-1:0] i_left_burst,
    input  logic [CW-1:0] i_left_id,
    input  logic [BW-1:0] i_right_burst,
    input  logic [CW-1:0] i_right_id,
    output logic          o_gt,
    output logic [BW-1:0] o_burst,
    output logic [CW-1:0] o_id
);

    localparam logic [CW-1:0] IDX_V = CW'(IDX);

    logic [BW-1:0] r_burst;
    logic [CW-1:0] r_id;
    logic          occupied;
    logic          take;

    always_comb begin
        occupied = i_count > IDX_V;
        o_gt     = occupied && (r_burst > i_new_burst);
        take     = occupied ? o_gt : (i_count == IDX_V);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && take) begin
            if (i_left_gt) begin
                r_burst <= i_left_burst;
                r_id    <= i_left_id;
            end else begin
                r_burst <= i_new_burst;
                r_id    <= i_new_id;
            end
        end else if (i_ctrl.pop) begin
            r_burst <= i_right_burst;
            r_id    <= i_right_id;
        end
    end

    assign o_burst = r_burst;
    assign o_id    = r_id;

endmodule

>>> rtl/sjf_div.sv
module sjf_div #(
    parameter int NW = 34,
    parameter int DW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [NW-1:0] o_quotient
);

    localparam int KW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        fits    = shifted >= {1'b0, i_divisor};
        diff    = shifted - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= KW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

>>> rtl/shortest_job_first_scheduler_top.sv
// Insertion: one word per cycle while idle; a row of cells keeps the jobs sorted.
// Output: after a batch-end word, one result per cycle as the row shifts out while
// the receiver is ready, then the final result after a bit-serial divide of the
// totals by the job count; no new word during that time.
// Reset: synchronous, active low; clears job count, state and output valid.
// Stored bursts and ids hold no reset value.
module shortest_job_first_scheduler_top import sjf_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_BURST_W-1:0] i_burst_time,
    input  logic                  i_batch_end,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PROC_W-1:0]     o_proc_number,
    output logic [TIME_W-1:0]     o_waiting_time,
    output logic [TIME_W-1:0]     o_turnaround_time,
    output logic [AVG_W-1:0]      o_avg_wait_fx,
    output logic [AVG_W-1:0]      o_avg_turnaround_fx,
    output logic                  o_final_flag
);

    localparam int CW     = $clog2(MAX_PROCS + 1);
    localparam int WAIT_W = BURST_BITS + CW;
    localparam int TOT_W  = BURST_BITS + 2 * CW;
    localparam int DIVN_W = TOT_W + FRAC_BITS;
    localparam int BXW    = (BURST_BITS > IN_BURST_W) ? BURST_BITS : IN_BURST_W;
    localparam int IXW    = (CW > PROC_W) ? CW : PROC_W;
    localparam int WXW    = (WAIT_W > TIME_W) ? WAIT_W : TIME_W;
    localparam int QXW    = (DIVN_W > AVG_W) ? DIVN_W : AVG_W;

    localparam logic [CW-1:0] MAX_V = CW'(MAX_PROCS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DRAIN  = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_left, n_left;
    logic [CW-1:0]     r_n, n_n;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [TOT_W-1:0]  r_tot_w, n_tot_w;
    logic [TOT_W-1:0]  r_tot_t, n_tot_t;
    logic              r_ovalid, n_ovalid;

    logic [CW-1:0]     r_last_id;
    logic [WAIT_W-1:0] r_last_wait;
    logic [WAIT_W-1:0] r_last_turn;

    logic [PROC_W-1:0] r_proc;
    logic [TIME_W-1:0] r_wt;
    logic [TIME_W-1:0] r_tt;
    logic [AVG_W-1:0]  r_aw;
    logic [AVG_W-1:0]  r_at;
    logic              r_fin;

    t_cell_ctrl        ctrl;
    logic              accept_in;
    logic              out_free;
    logic              has_room;
    logic              load_mid;
    logic              load_fin;
    logic              div_start;
    logic              busy_w, busy_t;
    logic [DIVN_W-1:0] quo_w, quo_t;
    logic [BXW-1:0]    in_ext;
    logic [BURST_BITS-1:0] new_burst;
    logic [CW-1:0]     new_id;
    logic [WAIT_W-1:0] turn;

    logic [BURST_BITS-1:0] c_burst [MAX_PROCS];
    logic [CW-1:0]         c_id    [MAX_PROCS];
    logic [MAX_PROCS-1:0]  c_gt;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
            logic                  left_gt;
            logic [BURST_BITS-1:0] left_burst, right_burst;
            logic [CW-1:0]         left_id, right_id;

            if (gi == 0) begin : g_first
                assign left_gt    = 1'b0;
                assign left_burst = '0;
                assign left_id    = '0;
            end else begin : g_mid
                assign left_gt    = c_gt[gi-1];
                assign left_burst = c_burst[gi-1];
                assign left_id    = c_id[gi-1];
            end

            if (gi == MAX_PROCS - 1) begin : g_last
                assign right_burst = '0;
                assign right_id    = '0;
            end else begin : g_inner
                assign right_burst = c_burst[gi+1];
                assign right_id    = c_id[gi+1];
            end

            sjf_cell #(
                .BW  (BURST_BITS),
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (ctrl),
                .i_count       (r_count),
                .i_new_burst   (new_burst),
                .i_new_id      (new_id),
                .i_left_gt     (left_gt),
                .i_left_burst  (left_burst),
                .i_left_id     (left_id),
                .i_right_burst (right_burst),
                .i_right_id    (right_id),
                .o_gt          (c_gt[gi]),
                .o_burst       (c_burst[gi]),
                .o_id          (c_id[gi])
            );
        end
    endgenerate

    sjf_div #(
        .NW (DIVN_W),
        .DW (CW)
    ) u_div_wait (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_tot_w, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_n),
        .o_busy     (busy_w),
        .o_quotient (quo_w)
    );

    sjf_div #(
        .NW (DIVN_W),
        .DW (CW)
    ) u_div_turn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_tot_t, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_n),
        .o_busy     (busy_t),
        .o_quotient (quo_t)
    );

    always_comb begin
        o_ready   = (r_state == S_IDLE);
        accept_in = i_valid && o_ready;
        out_free  = !r_ovalid || i_ready;
        has_room  = r_count < MAX_V;
        in_ext    = BXW'(i_burst_time);
        new_burst = in_ext[BURST_BITS-1:0];
        new_id    = r_count + 1'b1;
        ctrl.ins  = accept_in && has_room;
        ctrl.pop  = (r_state == S_DRAIN) && out_free;
        turn      = r_wait + WAIT_W'(c_burst[0]);
        load_mid  = ctrl.pop && (r_left > CW'(1));
        load_fin  = (r_state == S_FINAL) && out_free;
        div_start = (r_state == S_DSTART);
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_n      = r_n;
        n_wait   = r_wait;
        n_tot_w  = r_tot_w;
        n_tot_t  = r_tot_t;
        n_ovalid = r_ovalid;

        if (load_mid || load_fin) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    if (has_room) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_batch_end) begin
                        n_n     = has_room ? r_count + 1'b1 : r_count;
                        n_left  = n_n;
                        n_count = '0;
                        n_wait  = '0;
                        n_tot_w = '0;
                        n_tot_t = '0;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (ctrl.pop) begin
                    n_wait  = turn;
                    n_tot_w = r_tot_w + TOT_W'(r_wait);
                    n_tot_t = r_tot_t + TOT_W'(turn);
                    n_left  = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_DSTART;
                    end
                end
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (!busy_w && !busy_t) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_wait  <= n_wait;
        r_tot_w <= n_tot_w;
        r_tot_t <= n_tot_t;
    end

    logic [IXW-1:0] id_head_x, id_last_x;
    logic [WXW-1:0] wait_x, turn_x, lwait_x, lturn_x;
    logic [QXW-1:0] qw_x, qt_x;

    always_comb begin
        id_head_x = IXW'(c_id[0]);
        id_last_x = IXW'(r_last_id);
        wait_x    = WXW'(r_wait);
        turn_x    = WXW'(turn);
        lwait_x   = WXW'(r_last_wait);
        lturn_x   = WXW'(r_last_turn);
        qw_x      = QXW'(quo_w);
        qt_x      = QXW'(quo_t);
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.pop && (r_left == CW'(1))) begin
            r_last_id   <= c_id[0];
            r_last_wait <= r_wait;
            r_last_turn <= turn;
        end
        if (load_mid) begin
            r_proc <= id_head_x[PROC_W-1:0];
            r_wt   <= wait_x[TIME_W-1:0];
            r_tt   <= turn_x[TIME_W-1:0];
            r_aw   <= '0;
            r_at   <= '0;
            r_fin  <= 1'b0;
        end else if (load_fin) begin
            r_proc <= id_last_x[PROC_W-1:0];
            r_wt   <= lwait_x[TIME_W-1:0];
            r_tt   <= lturn_x[TIME_W-1:0];
            r_aw   <= qw_x[AVG_W-1:0];
            r_at   <= qt_x[AVG_W-1:0];
            r_fin  <= 1'b1;
        end
    end

    assign o_valid             = r_ovalid;
    assign o_proc_number       = r_proc;
    assign o_waiting_time      = r_wt;
    assign o_turnaround_time   = r_tt;
    assign o_avg_wait_fx       = r_aw;
    assign o_avg_turnaround_fx = r_at;
    assign o_final_flag        = r_fin;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_V)
        else $error("job count beyond store depth");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy_w |-> (r_state == S_DWAIT))
        else $error("divider running outside wait state");

    a_batch_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && i_batch_end) |=> (r_state == S_DRAIN) && (r_count == '0))
        else $error("batch end did not start drain");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_fin |=> (r_state == S_IDLE) && o_valid && o_final_flag)
        else $error("final result not presented on return to idle");
`endif

endmodule
